// ----- sv/pas_pkg.sv -----
// pas_pkg: shared types, codes and constants of the priority aging scheduler
// no dependencies; imported by every module of the block
package pas_pkg;

  // sizes
  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = 4;
  localparam int COUNT_W    = $clog2(TASK_SLOTS + 1);

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic signed [5:0]  sprio_t;
  typedef logic signed [7:0]  dprio_t;

  // priority limits and aging floor
  localparam sprio_t PRIO_MAX  = 6'sd20;
  localparam sprio_t PRIO_MIN  = -6'sd20;
  localparam dprio_t DYN_FLOOR = -8'sd128;

  // request modes
  typedef enum logic [2:0] {
    MODE_CREATE  = 3'd0,
    MODE_REQUEUE = 3'd1,
    MODE_REMOVE  = 3'd2,
    MODE_SETPRIO = 3'd3,
    MODE_PICK    = 3'd4
  } mode_t;

  // response status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_BUSY  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } fsm_t;

  // control broadcast to every list cell
  typedef struct packed {
    logic   rotate;
    logic   append;
    logic   remove;
    slot_t  slot;
    count_t count;
  } cell_bus_t;

  // write port of the priority table
  typedef struct packed {
    logic   stat_en;
    logic   dyn_en;
    slot_t  slot;
    sprio_t stat;
    dprio_t dyn;
  } prio_wr_t;

endpackage

// ----- sv/pas_cell.sv -----
// pas_cell: one position of the ready list ring
// depends on pas_pkg for the cell control bus and slot types
module pas_cell import pas_pkg::*; (
  input  logic      clk,
  input  cell_bus_t bus,
  input  slot_t     pos,
  input  slot_t     neighbor_slot,
  input  logic      hit_in,
  output logic      hit_out,
  output slot_t     slot
);

  logic entry_valid;
  logic match;

  // position is occupied when it lies below the fill count
  assign entry_valid = count_t'(pos) < bus.count;
  assign match       = entry_valid && (slot == bus.slot);
  assign hit_out     = hit_in | match;

  // rotate for a scan, take the appended slot, or close the gap on remove
  always_ff @(posedge clk) begin
    if (bus.rotate) begin
      slot <= neighbor_slot;
    end else if (bus.append && (count_t'(pos) == bus.count)) begin
      slot <= bus.slot;
    end else if (bus.remove && hit_out) begin
      slot <= neighbor_slot;
    end
  end

endmodule

// ----- sv/pas_prio_table.sv -----
// pas_prio_table: static and dynamic priority of every task slot
// depends on pas_pkg; one write port, one read port per array
module pas_prio_table import pas_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  prio_wr_t wr,
  input  slot_t    dyn_addr,
  input  slot_t    stat_addr,
  output dprio_t   dyn_rd,
  output sprio_t   stat_rd
);

  sprio_t stat_q [TASK_SLOTS];
  dprio_t dyn_q  [TASK_SLOTS];

  // priority registers, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        stat_q[i] <= '0;
        dyn_q[i]  <= '0;
      end
    end else begin
      if (wr.stat_en) begin
        stat_q[wr.slot] <= wr.stat;
      end
      if (wr.dyn_en) begin
        dyn_q[wr.slot] <= wr.dyn;
      end
    end
  end

  // read ports
  assign dyn_rd  = dyn_q[dyn_addr];
  assign stat_rd = stat_q[stat_addr];

endmodule

// ----- sv/priority_aging_scheduler.sv -----
// priority_aging_scheduler: ready-list scheduler with priority aging
// depends on pas_pkg, pas_cell (ready list ring) and pas_prio_table
//
//  channel | handshake            | fields
//  --------+----------------------+---------------------------------------------
//  req     | req_valid, req_stall | mode, task_slot, to_current, priority_req
//  rsp     | rsp_valid, rsp_stall | chosen_slot, chosen_valid, status
//
// create, requeue, remove and set priority update state at the transfer edge; the
// result moves through the pending stage into the output register, and the next
// request is taken once the pending stage is empty. pick: the ring turns once past the
// head cell, the finish state reloads the winner's static priority, then the result moves out.
// a pending stage sits in front of the output register; requests wait while it is full.
// synchronous reset clears the fill count, all priorities and the current slot.
// rsp_stall only holds the result; req_stall is high while a pick runs and while the
// pending stage holds a result, longer when that result is behind a stalled output.
module priority_aging_scheduler import pas_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [2:0]        mode,
  input  logic [3:0]        task_slot,
  input  logic              to_current,
  input  logic signed [5:0] priority_req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [3:0]        chosen_slot,
  output logic              chosen_valid,
  output logic [1:0]        status
);

  fsm_t      state, state_next;
  count_t    ready_count, ready_count_next;
  slot_t     current_slot;
  slot_t     scan_idx;
  dprio_t    best;
  slot_t     win;
  cell_bus_t bus;
  prio_wr_t  wr;
  dprio_t    dyn_rd;
  sprio_t    stat_rd;
  slot_t     cell_slot [TASK_SLOTS];
  logic      hit [TASK_SLOTS+1];
  logic      listed;
  logic      full;
  logic      accept;
  logic      head_valid;
  logic      take_head;
  dprio_t    dyn_dec;
  slot_t     target;
  logic      res_load;
  logic      res_valid;
  slot_t     res_slot, res_slot_next;
  logic      res_chosen, res_chosen_next;
  status_t   res_status, res_status_next;
  logic      res_move;

  // ready list ring
  assign hit[0] = 1'b0;
  for (genvar k = 0; k < TASK_SLOTS; k++) begin : g_cell
    pas_cell u_cell (
      .clk           (clk),
      .bus           (bus),
      .pos           (slot_t'(k)),
      .neighbor_slot (cell_slot[(k + 1) % TASK_SLOTS]),
      .hit_in        (hit[k]),
      .hit_out       (hit[k+1]),
      .slot          (cell_slot[k])
    );
  end

  // per-slot priorities
  pas_prio_table u_prio (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .dyn_addr  (cell_slot[0]),
    .stat_addr (win),
    .dyn_rd    (dyn_rd),
    .stat_rd   (stat_rd)
  );

  assign listed     = hit[TASK_SLOTS];
  assign full       = ready_count == count_t'(TASK_SLOTS);
  assign req_stall  = (state != ST_IDLE) || res_valid;
  assign accept     = req_valid && !req_stall;
  assign head_valid = count_t'(scan_idx) < ready_count;
  assign take_head  = head_valid && ((scan_idx == '0) || (dyn_rd < best));
  assign dyn_dec    = (dyn_rd == DYN_FLOOR) ? dyn_rd : dyn_rd - 8'sd1;
  assign target     = to_current ? current_slot : task_slot;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (mode_t'(mode) == MODE_PICK) && (ready_count != '0)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx == slot_t'(TASK_SLOTS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // request decode, list control and priority writes
  always_comb begin
    bus              = '0;
    bus.slot         = task_slot;
    bus.count        = ready_count;
    wr               = '0;
    ready_count_next = ready_count;
    res_load         = 1'b0;
    res_slot_next    = '0;
    res_chosen_next  = 1'b0;
    res_status_next  = STATUS_OK;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          unique case (mode_t'(mode)) inside
            MODE_CREATE, MODE_REQUEUE: begin
              if (!listed && full) begin
                res_status_next = STATUS_BUSY;
              end else begin
                if (!listed) begin
                  bus.append       = 1'b1;
                  ready_count_next = ready_count + count_t'(1);
                end
                if (mode_t'(mode) == MODE_CREATE) begin
                  wr.stat_en = 1'b1;
                  wr.dyn_en  = 1'b1;
                  wr.slot    = task_slot;
                end
              end
            end
            MODE_REMOVE: begin
              if (listed) begin
                bus.remove       = 1'b1;
                ready_count_next = ready_count - count_t'(1);
              end else if (ready_count == '0) begin
                res_status_next = STATUS_BUSY;
              end
            end
            MODE_SETPRIO: begin
              if ((priority_req > PRIO_MAX) || (priority_req < PRIO_MIN)) begin
                res_status_next = STATUS_RANGE;
              end else begin
                wr.stat_en = 1'b1;
                wr.dyn_en  = 1'b1;
                wr.slot    = target;
                wr.stat    = priority_req;
                wr.dyn     = dprio_t'(priority_req);
              end
            end
            MODE_PICK: begin
              if (ready_count == '0) begin
                res_status_next = STATUS_BUSY;
              end else begin
                res_load = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // head entry ages as it passes
        bus.rotate = 1'b1;
        wr.dyn_en  = head_valid;
        wr.slot    = cell_slot[0];
        wr.dyn     = dyn_dec;
      end
      ST_FINISH: begin
        // winner reloads its static priority
        wr.dyn_en       = 1'b1;
        wr.slot         = win;
        wr.dyn          = dprio_t'(stat_rd);
        res_load        = 1'b1;
        res_slot_next   = win;
        res_chosen_next = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ready_count  <= '0;
      current_slot <= '0;
      scan_idx     <= '0;
    end else begin
      state       <= state_next;
      ready_count <= ready_count_next;
      if (state == ST_FINISH) begin
        current_slot <= win;
      end
      if (state == ST_SCAN) begin
        scan_idx <= scan_idx + slot_t'(1);
      end else begin
        scan_idx <= '0;
      end
    end
  end

  // running minimum of the scan
  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && take_head) begin
      best <= dyn_rd;
      win  <= cell_slot[0];
    end
  end

  // pending result and output register
  assign res_move = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      if (res_move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_slot   <= res_slot_next;
      res_chosen <= res_chosen_next;
      res_status <= res_status_next;
    end
    if (res_move) begin
      chosen_slot  <= res_slot;
      chosen_valid <= res_chosen;
      status       <= res_status;
    end
  end

  // list never overfills
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    ready_count <= count_t'(TASK_SLOTS))
    else $error("ready count beyond slot count");

  // list length moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (ready_count == $past(ready_count)) ||
             (ready_count == $past(ready_count) + count_t'(1)) ||
             (ready_count == $past(ready_count) - count_t'(1)))
    else $error("ready count jumped");

  // finish only follows a full scan turn
  a_finish_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> ($past(state) == ST_SCAN) &&
                             ($past(scan_idx) == slot_t'(TASK_SLOTS - 1)))
    else $error("finish without completed scan");

  // no pending result while a pick is in flight
  a_no_pending_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !res_valid)
    else $error("pending result during pick");

  // a chosen task always comes with an ok status
  a_chosen_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && chosen_valid) |-> (status == STATUS_OK))
    else $error("chosen task with error status");

endmodule
